// ===== rtl/prdt_pkg.sv =====
// ----------------------------------------------------------------------------
// prdt_pkg
// Shared widths, codes, types and helpers for the round-robin dispatcher
// with rebuild throttle.
// ----------------------------------------------------------------------------
package prdt_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int OP_W        = 3;
  localparam int CLS_W       = 2;
  localparam int DIR_W       = 2;
  localparam int SIZE_W      = 32;
  localparam int MAX_W       = 63;
  localparam int SCALE_W     = 32;
  localparam int BUD_W       = 64;
  localparam int BUSY_W      = 32;
  localparam int ARR_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(MAX_W);

  // op codes
  localparam logic [OP_W-1:0] OP_SUBMIT = 3'd0;
  localparam logic [OP_W-1:0] OP_ADMIT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REFILL = 3'd2;
  localparam logic [OP_W-1:0] OP_BUSY   = 3'd3;
  localparam logic [OP_W-1:0] OP_ARRAY  = 3'd4;

  // request classes and directions
  localparam logic [CLS_W-1:0] CLS_FRONTEND = 2'd1;
  localparam logic [CLS_W-1:0] CLS_REBUILD  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_READ     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_WRITE    = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REACTOR_TOTAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONTEND_SLOTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_SCALE   = 3'd4;

  // configuration reset values
  localparam logic [CNT_W-1:0]   RT_RST    = 7'd64;
  localparam logic [CNT_W-1:0]   FC_RST    = 7'd19;
  localparam logic [MAX_W-1:0]   MAX_RST   = {MAX_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd1;

  localparam logic signed [ARR_W-1:0] ARR_HI = 16'sh7fff;
  localparam logic signed [ARR_W-1:0] ARR_LO = 16'sh8000;

  typedef enum logic [2:0] {
    K_NOP, K_SUBMIT, K_ADMIT, K_REFILL, K_BUSY, K_ARRAY
  } kind_t;

  typedef enum logic [1:0] {C_OTHER, C_FRONTEND, C_REBUILD} cls_t;
  typedef enum logic [1:0] {D_READ, D_WRITE, D_OTHER} dir_t;

  typedef struct packed {
    kind_t             kind;
    cls_t              cls;
    dir_t              dir;
    logic [SIZE_W-1:0] size;
    logic              was_reb;
    logic              now_reb;
  } item_t;

  function automatic logic [CNT_W-1:0] eff_total(input logic [CNT_W-1:0] rt);
    logic [CNT_W-1:0] t;
    t = rt;
    if (t == '0) t = CNT_W'(1);
    if (int'(t) > MAX_SLOTS) t = CNT_W'(MAX_SLOTS);
    return t;
  endfunction

  function automatic logic [CNT_W-1:0] eff_front(input logic [CNT_W-1:0] fc,
                                                 input logic [CNT_W-1:0] t);
    return (fc < t) ? fc : t;
  endfunction

  localparam logic THR_RST = eff_total(RT_RST) > eff_front(FC_RST, eff_total(RT_RST));

endpackage

// ===== rtl/prdt_if.sv =====
// ----------------------------------------------------------------------------
// prdt_in_if / prdt_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface prdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [prdt_pkg::OP_W-1:0]     op;
  logic [prdt_pkg::CLS_W-1:0]    request_class;
  logic [prdt_pkg::DIR_W-1:0]    direction;
  logic [prdt_pkg::SIZE_W-1:0]   request_size;
  logic                          was_rebuilding;
  logic                          now_rebuilding;

  modport source (output valid, op, request_class, direction, request_size,
                  was_rebuilding, now_rebuilding, input ready);
  modport sink   (input valid, op, request_class, direction, request_size,
                  was_rebuilding, now_rebuilding, output ready);
endinterface

interface prdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [prdt_pkg::SLOT_W-1:0]   target_slot;
  logic                          admitted;
  logic                          scheduling_on;
  logic                          count_underflow;

  modport source (output valid, target_slot, admitted, scheduling_on,
                  count_underflow, input ready);
  modport sink   (input valid, target_slot, admitted, scheduling_on,
                  count_underflow, output ready);
endinterface

// ===== rtl/prdt_front.sv =====
// ----------------------------------------------------------------------------
// prdt_front
// Accepts request items and classifies op, class and direction for the queue.
// ----------------------------------------------------------------------------
module prdt_front (
  prdt_in_if.sink          in_if,
  input  logic             q_full,
  output logic             push,
  output prdt_pkg::item_t  push_item
);
  import prdt_pkg::*;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    push_item.size    = in_if.request_size;
    push_item.was_reb = in_if.was_rebuilding;
    push_item.now_reb = in_if.now_rebuilding;

    unique case (in_if.op)
      OP_SUBMIT: push_item.kind = K_SUBMIT;
      OP_ADMIT:  push_item.kind = K_ADMIT;
      OP_REFILL: push_item.kind = K_REFILL;
      OP_BUSY:   push_item.kind = K_BUSY;
      OP_ARRAY:  push_item.kind = K_ARRAY;
      default:   push_item.kind = K_NOP;
    endcase

    unique case (in_if.request_class)
      CLS_FRONTEND: push_item.cls = C_FRONTEND;
      CLS_REBUILD:  push_item.cls = C_REBUILD;
      default:      push_item.cls = C_OTHER;
    endcase

    unique case (in_if.direction)
      DIR_READ:  push_item.dir = D_READ;
      DIR_WRITE: push_item.dir = D_WRITE;
      default:   push_item.dir = D_OTHER;
    endcase
  end

endmodule

// ===== rtl/prdt_queue.sv =====
// ----------------------------------------------------------------------------
// prdt_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module prdt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prdt_pkg::item_t  push_item,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output prdt_pkg::item_t  head_item
);
  import prdt_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] cnt_r,  cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_item;
    end
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/prdt_div.sv =====
// ----------------------------------------------------------------------------
// prdt_div
// Two restoring dividers sharing one step counter: both budget maxima are
// divided by the refill scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prdt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [prdt_pkg::MAX_W-1:0]     num_a,
  input  logic [prdt_pkg::MAX_W-1:0]     num_b,
  input  logic [prdt_pkg::SCALE_W-1:0]   scale,
  output logic                           busy,
  output logic [prdt_pkg::MAX_W-1:0]     quo_a,
  output logic [prdt_pkg::MAX_W-1:0]     quo_b
);
  import prdt_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [MAX_W-1:0]     na_r,   na_nxt;
  logic [MAX_W-1:0]     nb_r,   nb_nxt;
  logic [SCALE_W-1:0]   ra_r,   ra_nxt;
  logic [SCALE_W-1:0]   rb_r,   rb_nxt;
  logic [SCALE_W-1:0]   s_r,    s_nxt;
  logic [SCALE_W:0]     sh_a, sh_b, df_a, df_b;
  logic                 ge_a, ge_b;

  assign busy  = busy_r;
  assign quo_a = na_r;
  assign quo_b = nb_r;

  always_comb begin
    sh_a = {ra_r, na_r[MAX_W-1]};
    sh_b = {rb_r, nb_r[MAX_W-1]};
    df_a = sh_a - {1'b0, s_r};
    df_b = sh_b - {1'b0, s_r};
    ge_a = sh_a >= {1'b0, s_r};
    ge_b = sh_b >= {1'b0, s_r};

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    s_nxt    = s_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(MAX_W - 1);
      na_nxt   = num_a;
      nb_nxt   = num_b;
      ra_nxt   = '0;
      rb_nxt   = '0;
      // zero scale behaves as one
      s_nxt    = (scale == '0) ? SCALE_W'(1) : scale;
    end else if (busy_r) begin
      na_nxt = {na_r[MAX_W-2:0], ge_a};
      nb_nxt = {nb_r[MAX_W-2:0], ge_b};
      ra_nxt = ge_a ? df_a[SCALE_W-1:0] : sh_a[SCALE_W-1:0];
      rb_nxt = ge_b ? df_b[SCALE_W-1:0] : sh_b[SCALE_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    na_r  <= na_nxt;
    nb_r  <= nb_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    s_r   <= s_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== rtl/prdt_back.sv =====
// ----------------------------------------------------------------------------
// prdt_back
// Executes classified items: slot pick, admit budget, ticks, array count,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module prdt_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [prdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prdt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_not_empty,
  input  prdt_pkg::item_t                    q_item,
  output logic                               q_pop,
  prdt_out_if.source                         out_if
);
  import prdt_pkg::*;

  typedef enum logic {S_EXEC, S_DIV} state_t;

  state_t                  st_r, st_nxt;

  logic [CNT_W-1:0]        rt_r, rt_nxt;
  logic [CNT_W-1:0]        fc_r, fc_nxt;
  logic [MAX_W-1:0]        rd_max_r, rd_max_nxt;
  logic [MAX_W-1:0]        wr_max_r, wr_max_nxt;
  logic [SCALE_W-1:0]      scale_r, scale_nxt;

  logic [SLOT_W-1:0]       idx_com_r, idx_com_nxt;
  logic [SLOT_W-1:0]       idx_fe_r,  idx_fe_nxt;
  logic [SLOT_W-1:0]       idx_rb_r,  idx_rb_nxt;
  logic signed [BUD_W-1:0] rd_rem_r, rd_rem_nxt;
  logic signed [BUD_W-1:0] wr_rem_r, wr_rem_nxt;
  logic [BUSY_W-1:0]       busy_cnt_r, busy_cnt_nxt;
  logic                    thr_r, thr_nxt;
  logic signed [ARR_W-1:0] arr_r, arr_nxt, arr_up;

  logic                    out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    adm_r, adm_nxt;
  logic                    sched_r, sched_nxt;
  logic                    unf_r, unf_nxt;

  logic [CNT_W-1:0]        t, f, cfg_t, cfg_rt, cfg_fc;
  logic                    sched, out_free, use_fe, use_rb;
  logic [CNT_W-1:0]        rng_lo, rng_hi, cur_raw, cur, nxt_idx;
  logic signed [BUD_W-1:0] size_ext;
  logic                    div_start, div_busy;
  logic [MAX_W-1:0]        quo_rd, quo_wr;

  prdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_a (rd_max_r),
    .num_b (wr_max_r),
    .scale (scale_r),
    .busy  (div_busy),
    .quo_a (quo_rd),
    .quo_b (quo_wr)
  );

  assign out_if.valid           = out_vld_r;
  assign out_if.target_slot     = slot_r;
  assign out_if.admitted        = adm_r;
  assign out_if.scheduling_on   = sched_r;
  assign out_if.count_underflow = unf_r;

  assign t        = eff_total(rt_r);
  assign f        = eff_front(fc_r, t);
  assign sched    = arr_r > 0;
  assign out_free = !out_vld_r || out_if.ready;
  assign q_pop    = q_not_empty && (st_r == S_EXEC) && out_free;
  assign div_start = q_pop && (q_item.kind == K_REFILL) && thr_r;
  assign size_ext = signed'({{(BUD_W - SIZE_W){1'b0}}, q_item.size});

  // slot range of the class, wrap inside it
  always_comb begin
    use_fe  = (q_item.cls == C_FRONTEND) && sched && (f != '0);
    use_rb  = (q_item.cls == C_REBUILD) && sched && thr_r && (t > f);
    rng_lo  = use_rb ? f : '0;
    rng_hi  = use_fe ? f : t;
    if (use_fe) begin
      cur_raw = {1'b0, idx_fe_r};
    end else if (use_rb) begin
      cur_raw = {1'b0, idx_rb_r};
    end else begin
      cur_raw = {1'b0, idx_com_r};
    end
    cur     = (cur_raw < rng_lo || cur_raw >= rng_hi) ? rng_lo : cur_raw;
    nxt_idx = (cur + 1'b1 == rng_hi) ? rng_lo : cur + 1'b1;
  end

  // register write: slot counts also reload the throttle flag
  always_comb begin
    cfg_rt = (cfg_index == CFG_REACTOR_TOTAL)  ? cfg_data[CNT_W-1:0] : rt_r;
    cfg_fc = (cfg_index == CFG_FRONTEND_SLOTS) ? cfg_data[CNT_W-1:0] : fc_r;
    cfg_t  = eff_total(cfg_rt);
  end

  always_comb begin
    st_nxt       = st_r;
    rt_nxt       = rt_r;
    fc_nxt       = fc_r;
    rd_max_nxt   = rd_max_r;
    wr_max_nxt   = wr_max_r;
    scale_nxt    = scale_r;
    idx_com_nxt  = idx_com_r;
    idx_fe_nxt   = idx_fe_r;
    idx_rb_nxt   = idx_rb_r;
    rd_rem_nxt   = rd_rem_r;
    wr_rem_nxt   = wr_rem_r;
    busy_cnt_nxt = busy_cnt_r;
    thr_nxt      = thr_r;
    arr_nxt      = arr_r;
    arr_up       = arr_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    slot_nxt     = slot_r;
    adm_nxt      = adm_r;
    sched_nxt    = sched_r;
    unf_nxt      = unf_r;

    if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_REACTOR_TOTAL, CFG_FRONTEND_SLOTS: begin
          rt_nxt  = cfg_rt;
          fc_nxt  = cfg_fc;
          thr_nxt = cfg_t > eff_front(cfg_fc, cfg_t);
        end
        CFG_READ_MAX:     rd_max_nxt = cfg_data[MAX_W-1:0];
        CFG_WRITE_MAX:    wr_max_nxt = cfg_data[MAX_W-1:0];
        CFG_REFILL_SCALE: scale_nxt  = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end

    unique case (st_r)
      S_EXEC: begin
        if (q_pop && !div_start) begin
          out_vld_nxt = 1'b1;
          slot_nxt    = '0;
          adm_nxt     = 1'b0;
          unique case (q_item.kind)
            K_SUBMIT: begin
              slot_nxt = cur[SLOT_W-1:0];
              if (use_fe) begin
                idx_fe_nxt = nxt_idx[SLOT_W-1:0];
              end else if (use_rb) begin
                idx_rb_nxt = nxt_idx[SLOT_W-1:0];
              end else begin
                idx_com_nxt = nxt_idx[SLOT_W-1:0];
              end
              if (q_item.cls == C_FRONTEND && busy_cnt_r != '1) begin
                busy_cnt_nxt = busy_cnt_r + 1'b1;
              end
            end
            K_ADMIT: begin
              adm_nxt = 1'b1;
              if (q_item.cls == C_REBUILD && thr_r) begin
                if (q_item.dir == D_WRITE) begin
                  if (wr_rem_r < 0) adm_nxt = 1'b0;
                  else wr_rem_nxt = wr_rem_r - size_ext;
                end else if (q_item.dir == D_READ) begin
                  if (rd_rem_r < 0) adm_nxt = 1'b0;
                  else rd_rem_nxt = rd_rem_r - size_ext;
                end
              end
            end
            K_BUSY: begin
              thr_nxt      = (busy_cnt_r != '0) && (t > f);
              busy_cnt_nxt = '0;
            end
            K_ARRAY: begin
              if (q_item.now_reb && arr_r != ARR_HI) arr_up = arr_r + 1'b1;
              arr_nxt = arr_up;
              if (q_item.was_reb && arr_up != ARR_LO) arr_nxt = arr_up - 1'b1;
            end
            default: ;
          endcase
          sched_nxt = arr_nxt > 0;
          unf_nxt   = arr_nxt < 0;
        end else if (div_start) begin
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          st_nxt      = S_EXEC;
          rd_rem_nxt  = signed'({1'b0, quo_rd});
          wr_rem_nxt  = signed'({1'b0, quo_wr});
          out_vld_nxt = 1'b1;
          slot_nxt    = '0;
          adm_nxt     = 1'b0;
          sched_nxt   = arr_r > 0;
          unf_nxt     = arr_r < 0;
        end
      end
      default: st_nxt = S_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    adm_r      <= adm_nxt;
    sched_r    <= sched_nxt;
    unf_r      <= unf_nxt;
    if (!rst_n) begin
      st_r       <= S_EXEC;
      rt_r       <= RT_RST;
      fc_r       <= FC_RST;
      rd_max_r   <= MAX_RST;
      wr_max_r   <= MAX_RST;
      scale_r    <= SCALE_RST;
      idx_com_r  <= '0;
      idx_fe_r   <= '0;
      idx_rb_r   <= '0;
      rd_rem_r   <= signed'({1'b0, MAX_RST});
      wr_rem_r   <= signed'({1'b0, MAX_RST});
      busy_cnt_r <= '0;
      thr_r      <= THR_RST;
      arr_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      rt_r       <= rt_nxt;
      fc_r       <= fc_nxt;
      rd_max_r   <= rd_max_nxt;
      wr_max_r   <= wr_max_nxt;
      scale_r    <= scale_nxt;
      idx_com_r  <= idx_com_nxt;
      idx_fe_r   <= idx_fe_nxt;
      idx_rb_r   <= idx_rb_nxt;
      rd_rem_r   <= rd_rem_nxt;
      wr_rem_r   <= wr_rem_nxt;
      busy_cnt_r <= busy_cnt_nxt;
      thr_r      <= thr_nxt;
      arr_r      <= arr_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/partitioned_rr_dispatch_throttle.sv =====
// ----------------------------------------------------------------------------
// partitioned_rr_dispatch_throttle
// Round-robin slot dispatcher with class partitions and a rebuild budget.
//
//   channel   dir   handshake          carries
//   in_if     in    valid/ready        op, class, direction, size, array flags
//   out_if    out   valid/ready        target slot, admitted, status flags
//   cfg_*     in    write enable only  register index, write data
//
// Submit, admit, busy tick, array change, unknown ops, refills with throttling
// off: one item per cycle while the result register is not stalled, through
// the queue, then the result register. A refill tick with throttling on runs
// the 63-step shared divider, and the back end holds the queue meanwhile.
// A two-entry queue lets the input keep taking items while the result waits.
// Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module partitioned_rr_dispatch_throttle (
  input  logic                              clk,
  input  logic                              rst_n,
  prdt_in_if.sink                           in_if,
  prdt_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [prdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prdt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prdt_pkg::*;

  logic  push, pop, q_full, q_not_empty;
  item_t push_item, head_item;

  prdt_front u_front (
    .in_if     (in_if),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  prdt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  prdt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (pop),
    .out_if      (out_if)
  );

endmodule

// ===== rtl/prdt_checker.sv =====
// ----------------------------------------------------------------------------
// prdt_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module prdt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prdt_pkg::SLOT_W-1:0]   target_slot,
  input logic                          admitted,
  input logic                          scheduling_on,
  input logic                          count_underflow
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // array count cannot be both positive and negative
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(scheduling_on && count_underflow))
    else $error("scheduling and underflow both set");

  // a slot only comes from a submit, admitted only from an admit check
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(admitted && target_slot != '0))
    else $error("slot and admit in one result");

endmodule

bind partitioned_rr_dispatch_throttle prdt_checker u_prdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .target_slot     (out_if.target_slot),
  .admitted        (out_if.admitted),
  .scheduling_on   (out_if.scheduling_on),
  .count_underflow (out_if.count_underflow)
);

// ===== tb/tb_partitioned_rr_dispatch_throttle.sv =====
// ----------------------------------------------------------------------------
// tb_partitioned_rr_dispatch_throttle
// Self-checking bench for the partitioned round-robin dispatcher. Request
// items come from a queue through a bursty valid/ready driver, results are
// taken by a stalling receiver, and each one is compared field by field with
// an in-bench prediction of slot choice, rebuild budget and array count.
// ----------------------------------------------------------------------------
module tb_partitioned_rr_dispatch_throttle;
  timeunit 1ns;
  timeprecision 1ps;

  import prdt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 100;
  localparam int MISMATCH_SHOWN = 10;
  localparam int PHASE_ITEMS = 150;

  localparam logic [OP_W-1:0]  OP_TOP    = '1;
  localparam logic [CLS_W-1:0] CLS_OTHER = C_OTHER;
  localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
  localparam logic [DIR_W-1:0] DIR_OTHER = D_OTHER;
  localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;
  localparam logic [MAX_W-1:0] BUDGET_TOP = '1;
  localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

  typedef enum logic [1:0] {RNG_ALL, RNG_FRONT, RNG_REBUILD} slot_range_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CLS_W-1:0]  cls;
    logic [DIR_W-1:0]  dir;
    logic [SIZE_W-1:0] size;
    logic              was;
    logic              now;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              admitted;
    logic              sched;
    logic              under;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic in_valid = 1'b0;
  req_t in_req = '0;
  logic out_ready = 1'b0;

  prdt_in_if  in_ch ();
  prdt_out_if out_ch ();

  assign in_ch.valid          = in_valid;
  assign in_ch.op             = in_req.op;
  assign in_ch.request_class  = in_req.cls;
  assign in_ch.direction      = in_req.dir;
  assign in_ch.request_size   = in_req.size;
  assign in_ch.was_rebuilding = in_req.was;
  assign in_ch.now_rebuilding = in_req.now;
  assign out_ch.ready         = out_ready;

  partitioned_rr_dispatch_throttle dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted block state
  logic [CNT_W-1:0]          cfg_total;
  logic [CNT_W-1:0]          cfg_front;
  logic [MAX_W-1:0]          cfg_rd_max;
  logic [MAX_W-1:0]          cfg_wr_max;
  logic [SCALE_W-1:0]        cfg_scale;
  logic [SLOT_W-1:0]         idx_common;
  logic [SLOT_W-1:0]         idx_front;
  logic [SLOT_W-1:0]         idx_rebuild;
  logic signed [BUD_W-1:0]   rd_left;
  logic signed [BUD_W-1:0]   wr_left;
  logic [BUSY_W-1:0]         front_busy;
  logic                      throttle;
  logic signed [ARR_W-1:0]   arrays;

  req_t queued_requests[$];
  res_t due_outcomes[$];
  int   issued_cnt = 0;
  int   accepted_cnt = 0;
  int   checked_cnt = 0;
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   part_picks = 0;
  int   retries = 0;
  int   settings_cnt = 1;
  int   gen_arrays = 0;

  function automatic int usable_total();
    int t;
    t = int'(cfg_total);
    if (t < 1) t = 1;
    if (t > MAX_SLOTS) t = MAX_SLOTS;
    return t;
  endfunction

  function automatic int frontend_span();
    int t;
    t = usable_total();
    return (int'(cfg_front) < t) ? int'(cfg_front) : t;
  endfunction

  function automatic res_t dispatch_outcome(input req_t r);
    res_t e;
    int t, f, cur, start, cnt;
    slot_range_t rng;
    logic sched;
    logic [BUD_W-1:0] s;
    t = usable_total();
    f = frontend_span();
    sched = arrays > 0;
    e = '0;
    case (r.op)
      OP_SUBMIT: begin
        if (r.cls == CLS_FRONTEND && sched && f > 0) begin
          rng = RNG_FRONT; start = 0; cnt = f; cur = int'(idx_front);
        end else if (r.cls == CLS_REBUILD && sched && throttle && t > f) begin
          rng = RNG_REBUILD; start = f; cnt = t - f; cur = int'(idx_rebuild);
        end else begin
          rng = RNG_ALL; start = 0; cnt = t; cur = int'(idx_common);
        end
        // a stale index outside the range restarts at the range start
        if (cur < start || cur - start >= cnt) cur = start;
        e.slot = SLOT_W'(cur);
        cur = start + (cur - start + 1) % cnt;
        case (rng)
          RNG_FRONT:   idx_front = SLOT_W'(cur);
          RNG_REBUILD: idx_rebuild = SLOT_W'(cur);
          default:     idx_common = SLOT_W'(cur);
        endcase
        if (rng != RNG_ALL) part_picks++;
        if (r.cls == CLS_FRONTEND && front_busy != '1) front_busy++;
      end
      OP_ADMIT: begin
        e.admitted = 1'b1;
        if (r.cls == CLS_REBUILD && throttle) begin
          if (r.dir == DIR_WRITE) begin
            if (wr_left < 0) e.admitted = 1'b0;
            else wr_left -= $signed({32'd0, r.size});
          end else if (r.dir == DIR_READ) begin
            if (rd_left < 0) e.admitted = 1'b0;
            else rd_left -= $signed({32'd0, r.size});
          end
        end
        if (!e.admitted) retries++;
      end
      OP_REFILL: begin
        if (throttle) begin
          s = (cfg_scale == '0) ? BUD_W'(1) : BUD_W'(cfg_scale);
          rd_left = $signed({1'b0, cfg_rd_max} / s);
          wr_left = $signed({1'b0, cfg_wr_max} / s);
        end
      end
      OP_BUSY: begin
        throttle = (front_busy != '0) && (t > f);
        front_busy = '0;
      end
      OP_ARRAY: begin
        if (r.now && arrays != ARR_HI) arrays++;
        if (r.was && arrays != ARR_LO) arrays--;
      end
      default: ;
    endcase
    e.sched = arrays > 0;
    e.under = arrays < 0;
    return e;
  endfunction

  // sender: bursts with random gaps, held while the dut is not ready
  int gap_left = 0;
  int burst_left = 1;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) begin
        due_outcomes.push_back(dispatch_outcome(in_req));
        accepted_cnt++;
      end
      if (!in_valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          in_req <= queued_requests.pop_front();
          in_valid <= 1'b1;
          issued_cnt++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: draws its mode anew each time its 8-bit timer wraps
  logic [7:0] rx_timer = '0;
  int rx_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
          end
        endcase
      end
      rx_timer <= rx_timer + 8'd1;
      if (rx_timer == '0) rx_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    res_t e, a;
    if (rst_n && out_ch.valid && out_ready) begin
      a.slot = out_ch.target_slot;
      a.admitted = out_ch.admitted;
      a.sched = out_ch.scheduling_on;
      a.under = out_ch.count_underflow;
      if (due_outcomes.size() == 0) begin
        if (fail_cnt < MISMATCH_SHOWN)
          $display("unexpected result: slot %0d admitted %0b sched %0b underflow %0b",
                   a.slot, a.admitted, a.sched, a.under);
        fail_cnt++;
      end else begin
        e = due_outcomes.pop_front();
        if (e != a) begin
          if (fail_cnt < MISMATCH_SHOWN)
            $display({"mismatch on result %0d (exp/act): slot %0d/%0d admitted %0b/%0b",
                      " sched %0b/%0b underflow %0b/%0b"}, checked_cnt,
                     e.slot, a.slot, e.admitted, a.admitted, e.sched, a.sched,
                     e.under, a.under);
          fail_cnt++;
        end
        checked_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_outcomes.size());
      $display("tb_partitioned_rr_dispatch_throttle failed");
      $finish;
    end
  end

  task automatic push_req(input logic [OP_W-1:0] op, input logic [CLS_W-1:0] cls,
                          input logic [DIR_W-1:0] dir, input logic [SIZE_W-1:0] size,
                          input logic was, input logic now);
    req_t r;
    r = '{op: op, cls: cls, dir: dir, size: size, was: was, now: now};
    if (op == OP_ARRAY) gen_arrays += int'(now) - int'(was);
    queued_requests.push_back(r);
  endtask

  task automatic settle();
    while (queued_requests.size() != 0 || issued_cnt != accepted_cnt ||
           due_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REACTOR_TOTAL:  cfg_total = val[CNT_W-1:0];
      CFG_FRONTEND_SLOTS: cfg_front = val[CNT_W-1:0];
      CFG_READ_MAX:       cfg_rd_max = val[MAX_W-1:0];
      CFG_WRITE_MAX:      cfg_wr_max = val[MAX_W-1:0];
      CFG_REFILL_SCALE:   cfg_scale = val[SCALE_W-1:0];
      default: ;
    endcase
    if (idx == CFG_REACTOR_TOTAL || idx == CFG_FRONTEND_SLOTS)
      throttle = usable_total() > frontend_span();
  endtask

  task automatic program_registers(input int total, input int front,
                                   input logic [MAX_W-1:0] rd_max,
                                   input logic [MAX_W-1:0] wr_max,
                                   input logic [SCALE_W-1:0] scale);
    settle();
    cfg_write(CFG_REACTOR_TOTAL, CFG_DATA_W'(total));
    cfg_write(CFG_FRONTEND_SLOTS, CFG_DATA_W'(front));
    cfg_write(CFG_READ_MAX, CFG_DATA_W'(rd_max));
    cfg_write(CFG_WRITE_MAX, CFG_DATA_W'(wr_max));
    cfg_write(CFG_REFILL_SCALE, CFG_DATA_W'(scale));
    settings_cnt++;
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return SIZE_W'($urandom_range(0, 4096));
      2: return SIZE_W'($urandom_range(0, 65535));
      3: return SIZE_TOP;
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // weighted mix that keeps the array count mostly positive
  task automatic push_random_items(input int n);
    int sel;
    logic [CLS_W-1:0] cls;
    logic [DIR_W-1:0] dir;
    logic was, now;
    push_req(OP_REFILL, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      cls = CLS_W'($urandom_range(0, 3));
      dir = DIR_W'($urandom_range(0, 3));
      if (sel < 40) begin
        push_req(OP_SUBMIT, cls, dir, SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else if (sel < 70) begin
        if ($urandom_range(0, 9) < 6) cls = CLS_REBUILD;
        if ($urandom_range(0, 9) < 8) dir = DIR_W'($urandom_range(DIR_READ, DIR_WRITE));
        push_req(OP_ADMIT, cls, dir, random_size(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else if (sel < 82) begin
        if (gen_arrays <= 0 && $urandom_range(0, 9) < 8) begin
          was = 1'b0; now = 1'b1;
        end else if (gen_arrays >= 3 && $urandom_range(0, 9) < 7) begin
          was = 1'b1; now = 1'b0;
        end else begin
          was = 1'($urandom_range(0, 1)); now = 1'($urandom_range(0, 1));
        end
        push_req(OP_ARRAY, cls, dir, SIZE_W'($urandom), was, now);
      end else if (sel < 90) begin
        push_req(OP_BUSY, cls, dir, SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else if (sel < 95) begin
        push_req(OP_REFILL, cls, dir, SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else begin
        push_req(OP_W'($urandom_range(OP_ARRAY + 1, OP_TOP)), cls, dir,
                 SIZE_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int total;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_total = RT_RST;
    cfg_front = FC_RST;
    cfg_rd_max = MAX_RST;
    cfg_wr_max = MAX_RST;
    cfg_scale = SCALE_RST;
    idx_common = '0;
    idx_front = '0;
    idx_rebuild = '0;
    rd_left = $signed({1'b0, MAX_RST});
    wr_left = $signed({1'b0, MAX_RST});
    front_busy = '0;
    throttle = usable_total() > frontend_span();
    arrays = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass on reset settings
    push_req(OP_SUBMIT, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b1, 1'b0);   // goes negative
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b1);
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b1);
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b1, 1'b1);
    push_req(OP_SUBMIT, CLS_FRONTEND, DIR_READ, SIZE_TOP, 1'b1, 1'b1);
    push_req(OP_SUBMIT, CLS_REBUILD, DIR_WRITE, '0, 1'b0, 1'b0);
    push_req(OP_SUBMIT, CLS_SPARE, DIR_SPARE, SIZE_TOP, 1'b1, 1'b1);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_READ, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_WRITE, '0, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_OTHER, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_SPARE, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_FRONTEND, DIR_READ, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_REFILL, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_BUSY, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);   // frontend seen, stays on
    push_req(OP_BUSY, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);   // idle period, goes off
    push_req(OP_SUBMIT, CLS_REBUILD, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_READ, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_REFILL, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_W'(OP_ARRAY + 1), CLS_REBUILD, DIR_WRITE, SIZE_TOP, 1'b1, 1'b1);
    push_req(OP_TOP, CLS_FRONTEND, DIR_READ, SIZE_TOP, 1'b1, 1'b1);
    push_req(OP_ARRAY, CLS_OTHER, DIR_READ, '0, 1'b1, 1'b0);

    // small budgets: overspend once, then retry
    program_registers(8, 3, 63'd5000, 63'd3000, 32'd1);
    push_req(OP_REFILL, CLS_OTHER, DIR_READ, '0, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_READ, 32'd6000, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_READ, 32'd1, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_WRITE, SIZE_TOP, 1'b0, 1'b0);
    push_req(OP_ADMIT, CLS_REBUILD, DIR_WRITE, 32'd1, 1'b0, 1'b0);
    push_random_items(PHASE_ITEMS);

    program_registers(1, 0, '0, '0, '0);
    push_random_items(PHASE_ITEMS);
    program_registers(MAX_SLOTS, MAX_SLOTS, BUDGET_TOP, BUDGET_TOP, '1);
    push_random_items(PHASE_ITEMS);
    program_registers(127, 5, MAX_W'({$urandom, $urandom}), MAX_W'({$urandom, $urandom}),
                      32'd2);
    push_random_items(PHASE_ITEMS);
    program_registers(0, 1, 63'd100, 63'd100, 32'd1);
    push_random_items(PHASE_ITEMS);
    repeat (2) begin
      total = $urandom_range(2, MAX_SLOTS);
      program_registers(total, $urandom_range(0, total), MAX_W'($urandom_range(0, 20000)),
                        MAX_W'($urandom_range(0, 20000)), SCALE_W'($urandom_range(1, 4)));
      push_random_items(PHASE_ITEMS);
    end
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    fail_cnt += due_outcomes.size();
    $display("checked %0d results over %0d register settings: %0d partitioned picks, %0d retries",
             checked_cnt, settings_cnt, part_picks, retries);
    $display("array count taken below and above zero, budgets run negative and refilled");
    if (fail_cnt == 0) begin
      $display("tb_partitioned_rr_dispatch_throttle passed");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("tb_partitioned_rr_dispatch_throttle failed");
    end
    $finish;
  end

endmodule
